[rtl/sem_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants, types and kernel helpers for the Sobel edge block.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [FW_W-1:0] FW_RESET = 11'd640;
   localparam logic [FH_W-1:0] FH_RESET = 13'd480;

   // beat kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // datapath widths
   localparam int PIX_W  = 24;
   localparam int GRAD_W = 11;  // |sum| <= 4*255
   localparam int MAG_W  = 22;  // gx^2 + gy^2 <= 2*1020^2
   localparam int Q_W    = 8;

   typedef logic [PIX_W-1:0]         pix_type;
   typedef logic signed [GRAD_W-1:0] grad_type;
   typedef logic [2:0][MAG_W-1:0]    mag_arr_type;
   typedef logic [2:0][Q_W-1:0]      q_arr_type;

   // Sobel X coefficient for window row i, column j
   function automatic logic signed [2:0] kern_x(input int i, input int j);
      logic signed [2:0] s;
      s = (j == 0) ? -3'sd1 : ((j == 2) ? 3'sd1 : 3'sd0);
      return (i == 1) ? 3'(s <<< 1) : s;
   endfunction

   // Sobel Y coefficient for window row i, column j
   function automatic logic signed [2:0] kern_y(input int i, input int j);
      logic signed [2:0] s;
      s = (i == 0) ? -3'sd1 : ((i == 2) ? 3'sd1 : 3'sd0);
      return (j == 1) ? 3'(s <<< 1) : s;
   endfunction

endpackage

[rtl/sem_line_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_line_mem
// Line buffer RAM: older and newer row per column, one read and one write port.
// ----------------------------------------------------------------------------
module sem_line_mem
   import sem_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_WIDTH,
   parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [2*PIX_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [2*PIX_W-1:0] wr_data
);

   logic [2*PIX_W-1:0] mem [DEPTH];
   logic [2*PIX_W-1:0] rd_data_ff;

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sem_mag.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_mag
// Rounded square root for three channels, one result bit per cycle.
// ----------------------------------------------------------------------------
module sem_mag
   import sem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  mag_arr_type m_in,
   output logic        done,
   output q_arr_type   q_out
);

   mag_arr_type m_ff;
   q_arr_type   q_ff, q_in;
   logic [2:0]  bit_ff;
   logic        busy_ff;

   // largest q with q*(q-1) < m, searched MSB first
   always_comb begin
      logic [Q_W-1:0]   cand;
      logic [2*Q_W-1:0] f;
      q_in = q_ff;
      for (int ch = 0; ch < 3; ch++) begin
         cand = q_ff[ch] | (Q_W'(1) << bit_ff);
         f    = cand * (cand - Q_W'(1));
         if (MAG_W'(f) < m_ff[ch]) begin
            q_in[ch] = cand;
         end
      end
   end

   // busy while bits remain; done pulses once after the last bit
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else begin
         done <= busy_ff && !start && (bit_ff == 3'd0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff == 3'd0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         m_ff   <= m_in;
         q_ff   <= '0;
         bit_ff <= 3'(Q_W - 1);
      end else if (busy_ff) begin
         q_ff   <= q_in;
         bit_ff <= bit_ff - 3'd1;
      end
   end

   assign q_out = q_ff;

endmodule

[rtl/sobel_edge_magnitude_rgb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// 3x3 Sobel edge magnitude per RGB channel over a raster stream, line RAM based.
// A result beat holds the input from its accept through RAM read, window shift,
// gradient, square/root start, 8-step root search and output load; then the next
// beat can be accepted.
// A beat without a result frees the input after its push state, an ignored drain at once;
// a stalled result keeps the input closed until it reaches the output register.
// Reset is synchronous; line RAM contents stay undefined until written.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [7:0]            req_red_in,
   input  logic [7:0]            req_green_in,
   input  logic [7:0]            req_blue_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_red_out,
   output logic [7:0]            rsp_green_out,
   output logic [7:0]            rsp_blue_out,
   output logic                  rsp_last_in_frame,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW = $clog2(MAX_HEIGHT + 1) + 1;
   localparam int PW = $clog2(MAX_WIDTH + 3);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PUSH = 5'b00010,
      ST_GRAD = 5'b00100,
      ST_SQR  = 5'b01000,
      ST_MAG  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [FW_W-1:0] fw_ff;
   logic [FH_W-1:0] fh_ff;
   logic [PW-1:0]   pend_ff, age_ff, pend_in, age_in;
   logic [CW-1:0]   pcol_ff, col, col_next;
   logic [CW-1:0]   ocol_ff;
   logic [RW-1:0]   orow_ff;
   logic            drain_ff;
   pix_type         px_ff;
   logic [2:0][2:0][PIX_W-1:0] win_ff;
   grad_type [2:0]  gx_ff, gy_ff;
   mag_arr_type     sq_in;
   logic            last_ff, emit;
   logic            mag_start, mag_done;
   logic            mag_hold_ff, mag_load;
   q_arr_type       mag_q;
   logic [2*PIX_W-1:0] rd_data;
   logic [WW-1:0]   w;
   logic [HW-1:0]   h;
   logic            accept;

   // effective geometry
   always_comb begin
      logic [31:0] w32, h32;
      w32 = 32'(fw_ff);
      h32 = 32'(fh_ff);
      if (w32 == 32'd0) w32 = 32'd1;
      else if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
      if (h32 == 32'd0) h32 = 32'd1;
      else if (h32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
      w = WW'(w32);
      h = HW'(h32);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // line RAM column for this push
   always_comb begin
      col      = (WW'(pcol_ff) >= w) ? '0 : pcol_ff;
      col_next = (WW'(col) + WW'(1) >= w) ? '0 : CW'(col + CW'(1));
   end

   sem_line_mem #(
      .DEPTH(MAX_WIDTH),
      .AW(CW)
   ) u_mem (
      .clock  (clock),
      .rd_en  (accept),
      .rd_addr(col),
      .rd_data(rd_data),
      .wr_en  (state_ff == ST_PUSH),
      .wr_addr(col),
      .wr_data({rd_data[PIX_W-1:0], px_ff})
   );

   // pending / age bookkeeping for one beat
   always_comb begin
      logic [PW-1:0] a1, p1;
      a1 = (pend_ff != '0) ? age_ff + PW'(1) : age_ff;
      p1 = pend_ff;
      if (!drain_ff) begin
         if (pend_ff == '0) a1 = '0;
         p1 = pend_ff + PW'(1);
      end
      emit    = (p1 != '0) && (32'(a1) >= 32'(w) + 32'd1);
      pend_in = p1;
      age_in  = a1;
      if (emit) begin
         pend_in = p1 - PW'(1);
         age_in  = (pend_in == '0) ? '0 : a1 - PW'(1);
      end
   end

   // result moves to the output register once the slot is free
   assign mag_load = (mag_done || mag_hold_ff) && (!rsp_valid || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && !(req_type == REQ_DRAIN && pend_ff == '0)) state_in = ST_PUSH;
         ST_PUSH: state_in = emit ? ST_GRAD : ST_IDLE;
         ST_GRAD: state_in = ST_SQR;
         ST_SQR:  state_in = ST_MAG;
         ST_MAG: begin
            if (mag_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign mag_start = (state_ff == ST_SQR);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fw_ff    <= FW_RESET;
         fh_ff    <= FH_RESET;
         pend_ff  <= '0;
         age_ff   <= '0;
         pcol_ff  <= '0;
         ocol_ff  <= '0;
         orow_ff  <= '0;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en && (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT)) begin
            if (csr_index == CSR_FRAME_WIDTH) fw_ff <= csr_wdata[FW_W-1:0];
            else fh_ff <= csr_wdata[FH_W-1:0];
            pend_ff <= '0;
            age_ff  <= '0;
            pcol_ff <= '0;
            ocol_ff <= '0;
            orow_ff <= '0;
         end else if (state_ff == ST_PUSH) begin
            pend_ff <= pend_in;
            age_ff  <= age_in;
            pcol_ff <= col_next;
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= win_ff[i][2];
            end
            win_ff[0][2] <= rd_data[2*PIX_W-1:PIX_W];
            win_ff[1][2] <= rd_data[PIX_W-1:0];
            win_ff[2][2] <= px_ff;
         end else if (state_ff == ST_GRAD) begin
            // advance output position
            if (WW'(ocol_ff) + WW'(1) >= w) begin
               ocol_ff <= '0;
               orow_ff <= (HW'(orow_ff) + HW'(1) >= h) ? '0 : RW'(orow_ff + RW'(1));
            end else begin
               ocol_ff <= ocol_ff + CW'(1);
            end
         end
      end
   end

   // beat capture
   always_ff @(posedge clock) begin
      if (accept) begin
         drain_ff <= req_type;
         px_ff    <= (req_type == REQ_DRAIN) ? '0 : {req_red_in, req_green_in, req_blue_in};
      end
   end

   // gradients with frame-edge masking
   always_ff @(posedge clock) begin
      if (state_ff == ST_GRAD) begin
         for (int ch = 0; ch < 3; ch++) begin
            grad_type gx, gy, v;
            gx = '0;
            gy = '0;
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++) begin
                  v = grad_type'({3'b000, win_ff[i][j][16-8*ch +: 8]});
                  if (!((i == 0 && orow_ff == '0) ||
                        (i == 2 && HW'(orow_ff) + HW'(1) >= h) ||
                        (j == 0 && ocol_ff == '0) ||
                        (j == 2 && WW'(ocol_ff) + WW'(1) >= w))) begin
                     gx = gx + GRAD_W'(v * kern_x(i, j));
                     gy = gy + GRAD_W'(v * kern_y(i, j));
                  end
               end
            end
            gx_ff[ch] <= gx;
            gy_ff[ch] <= gy;
         end
         last_ff <= (WW'(ocol_ff) + WW'(1) == w) && (HW'(orow_ff) + HW'(1) == h);
      end
   end

   // squared magnitude, taken by the root search at its start
   always_comb begin
      logic signed [MAG_W-1:0] gxe, gye;
      for (int ch = 0; ch < 3; ch++) begin
         gxe = MAG_W'($signed(gx_ff[ch]));
         gye = MAG_W'($signed(gy_ff[ch]));
         sq_in[ch] = gxe * gxe + gye * gye;
      end
   end

   sem_mag u_mag (
      .clock (clock),
      .reset (reset),
      .start (mag_start),
      .m_in  (sq_in),
      .done  (mag_done),
      .q_out (mag_q)
   );

   // output register; a finished result waits here until the slot is free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid   <= 1'b0;
         mag_hold_ff <= 1'b0;
      end else begin
         rsp_valid   <= mag_load || (rsp_valid && !rsp_ready);
         mag_hold_ff <= (mag_done || mag_hold_ff) && !mag_load;
      end
   end

   always_ff @(posedge clock) begin
      if (mag_load) begin
         rsp_red_out       <= mag_q[0];
         rsp_green_out     <= mag_q[1];
         rsp_blue_out      <= mag_q[2];
         rsp_last_in_frame <= last_ff;
      end
   end

endmodule

[tb/sv/sobel_edge_magnitude_rgb_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_tb
// Self-checking bench for the streaming RGB Sobel magnitude block. A local
// line-store and window model predicts each output pixel. Frames of random
// geometry are streamed with and without drain runs, under several
// idle/stall mixes. Every output beat is compared against the oldest
// predicted pixel.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_tb
   import sem_pkg::*;
();

   localparam int MAXW        = DEF_MAX_WIDTH;
   localparam int MAXH        = DEF_MAX_HEIGHT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 20;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } edge_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = REQ_PIXEL;
   logic [7:0]            req_red_in = '0;
   logic [7:0]            req_green_in = '0;
   logic [7:0]            req_blue_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_red_out;
   logic [7:0]            rsp_green_out;
   logic [7:0]            rsp_blue_out;
   logic                  rsp_last_in_frame;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sobel_edge_magnitude_rgb uut (.*);

   // model state
   pix_type     older_line [MAXW];
   pix_type     newer_line [MAXW];
   pix_type     win [3][3];
   int unsigned col_pos, row_pos, backlog, age, line_col;
   int unsigned width_reg, height_reg;

   edge_pixel_type expected_pixels[$];
   int          errors = 0;
   int          beats_sent = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int unsigned cycles = 0;

   initial forever #1 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic int unsigned active_width();
      int unsigned w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > MAXW) w = MAXW;
      return w;
   endfunction

   function automatic int unsigned active_height();
      int unsigned h;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > MAXH) h = MAXH;
      return h;
   endfunction

   function automatic void shift_window(pix_type px, int unsigned w);
      int unsigned c;
      c = (line_col >= w) ? 0 : line_col;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = older_line[c];
      win[1][2] = newer_line[c];
      win[2][2] = px;
      older_line[c] = newer_line[c];
      newer_line[c] = px;
      line_col = (c + 1 >= w) ? 0 : c + 1;
   endfunction

   // rounded root, clamped: largest q <= 255 with q*(q-1) < m
   function automatic logic [7:0] rounded_root(int m);
      int q;
      q = 0;
      while (q < 255 && (q + 1) * q < m) q++;
      return q[7:0];
   endfunction

   function automatic void reset_model();
      foreach (older_line[i]) begin
         older_line[i] = '0;
         newer_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos = 0; row_pos = 0; backlog = 0; age = 0; line_col = 0;
      width_reg = FW_RESET;
      height_reg = FH_RESET;
   endfunction

   // returns 1 when the beat releases an output pixel
   function automatic bit predict_edge_pixel(logic kind, pix_type px, output edge_pixel_type res);
      int unsigned w, h, wh, k, r, c, shamt;
      int          gx, gy, v;
      logic [7:0]  mag [3];
      w = active_width();
      h = active_height();
      wh = w * h;
      res = '0;
      if (kind == REQ_DRAIN && backlog == 0) return 0;
      if (backlog > 0) age++;
      if (kind == REQ_PIXEL) begin
         shift_window(px, w);
         if (backlog == 0) age = 0;
         backlog++;
         if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
         end else begin
            col_pos++;
         end
      end else begin
         shift_window('0, w);
      end
      if (backlog == 0 || age < w + 1) return 0;
      k = ((row_pos * w + col_pos) % wh + wh - (backlog % wh)) % wh;
      r = k / w;
      c = k % w;
      for (int ch = 0; ch < 3; ch++) begin
         gx = 0;
         gy = 0;
         shamt = 16 - 8 * ch;
         for (int i = 0; i < 3; i++) begin
            // rows and columns outside the frame contribute nothing
            if ((i == 0 && r == 0) || (i == 2 && r + 1 >= h)) continue;
            for (int j = 0; j < 3; j++) begin
               if ((j == 0 && c == 0) || (j == 2 && c + 1 >= w)) continue;
               v = int'((win[i][j] >> shamt) & 24'hFF);
               gx += v * ((j == 0) ? -1 : (j == 2) ? 1 : 0) * ((i == 1) ? 2 : 1);
               gy += v * ((i == 0) ? -1 : (i == 2) ? 1 : 0) * ((j == 1) ? 2 : 1);
            end
         end
         mag[ch] = rounded_root(gx * gx + gy * gy);
      end
      res.red = mag[0];
      res.green = mag[1];
      res.blue = mag[2];
      res.last = (k == wh - 1);
      backlog--;
      age--;
      if (backlog == 0) age = 0;
      return 1;
   endfunction

   // ---------------- stimulus helpers ----------------
   task automatic send_beat(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      edge_pixel_type res;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (predict_edge_pixel(kind, {r, g, b}, res)) expected_pixels.push_back(res);
   endtask

   task automatic send_pixels(int n);
      repeat (n) send_beat(REQ_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)));
   endtask

   task automatic send_drains(int n);
      repeat (n) send_beat(REQ_DRAIN, 8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)));
   endtask

   // waits until every predicted pixel has arrived, then for the block to settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // drives one register write; the caller drops the write enable afterwards
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      if (idx == CSR_FRAME_WIDTH) width_reg = value & 11'h7FF;
      else height_reg = value & 13'h1FFF;
      col_pos = 0; row_pos = 0; backlog = 0; age = 0; line_col = 0;
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h);
      wait_quiet();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------- tests ----------------
   task automatic test_directed();
      set_geometry(4, 3);
      // hard edges on red/green, ramp on blue: drives magnitudes to clamp
      for (int i = 0; i < 12; i++)
         send_beat(REQ_PIXEL, (i & 1) ? 8'hFF : 8'h00, (i & 4) ? 8'hFF : 8'h00,
                   8'(i * 21));
      send_drains(5);
      send_drains(1);   // nothing pending: ignored
      set_geometry(0, 0);   // acts as 1x1
      send_beat(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_beat(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
      send_drains(2);
   endtask

   task automatic test_geometry_extremes();
      set_geometry(1, 8191);   // height clamps to the maximum
      send_pixels(10);
      send_drains(2);
      set_geometry(MAXW, 2);
      send_pixels(8);
   endtask

   task automatic test_random_frames(int idle_pct, int stall_pct, int n);
      int start, w, h;
      start = beats_sent;
      wait_quiet();
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      while (beats_sent - start < n) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         h = $urandom_range(6, 1);
         set_geometry(w, h);
         repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(9) == 0) begin
               // abandoned frame: the next geometry write discards it
               send_pixels($urandom_range(w * h));
               break;
            end
            send_pixels(w * h);
            // back-to-back frames leave the flush to the next frame
            if ($urandom_range(2) != 0) send_drains(w + 1 + $urandom_range(2));
         end
         if (backlog != 0 && col_pos == 0 && row_pos == 0) send_drains(w + 1);
      end
   endtask

   // output side: random back-pressure and beat checking
   always @(posedge clock) begin
      rsp_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      edge_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected beat %h %h %h last %b", $time, rsp_red_out,
                     rsp_green_out, rsp_blue_out, rsp_last_in_frame);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            if (want.red !== rsp_red_out) begin
               $display("%0t: red exp %h got %h", $time, want.red, rsp_red_out);
               errors++;
            end
            if (want.green !== rsp_green_out) begin
               $display("%0t: green exp %h got %h", $time, want.green, rsp_green_out);
               errors++;
            end
            if (want.blue !== rsp_blue_out) begin
               $display("%0t: blue exp %h got %h", $time, want.blue, rsp_blue_out);
               errors++;
            end
            if (want.last !== rsp_last_in_frame) begin
               $display("%0t: last exp %b got %b", $time, want.last, rsp_last_in_frame);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_geometry_extremes();
      test_random_frames(0, 0, 180);
      test_random_frames(49, 0, 180);
      test_random_frames(0, 49, 180);
      test_random_frames(36, 36, 180);
      wait_quiet();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[sobel_edge_magnitude_rgb.f]
rtl/sem_pkg.sv
rtl/sem_line_mem.sv
rtl/sem_mag.sv
rtl/sobel_edge_magnitude_rgb.sv
tb/sv/sobel_edge_magnitude_rgb_tb.sv
